// ===== src/isak_pkg.sv =====
`timescale 1ns / 1ps
package isak_pkg;

  // Divider operand widths, shared by the sequencer and the divider.
  localparam int DIV_DVD_W = 64;
  localparam int DIV_DVS_W = 32;

  // Pi in Q16.16, and the largest covariance value.
  localparam logic signed [31:0] PI_Q16 = 32'sd205887;
  localparam logic [30:0] MAX_P = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_GYRO_THR   = 3'd0;
  localparam logic [2:0] REG_ACCEL_THR  = 3'd1;
  localparam logic [2:0] REG_PROC_NOISE = 3'd2;
  localparam logic [2:0] REG_MEAS_NOISE = 3'd3;
  localparam logic [2:0] REG_INIT_COV   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [30:0] RST_GYRO_THR   = 31'd1966;
  localparam logic [30:0] RST_ACCEL_THR  = 31'd4588;
  localparam logic [30:0] RST_PROC_NOISE = 31'd6554;
  localparam logic [30:0] RST_MEAS_NOISE = 31'd6554;
  localparam logic [30:0] RST_INIT_COV   = 31'd6553600;

  // atan(2^-i) in Q16.16 for the CORDIC steps.
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/isak_div.sv =====
`timescale 1ns / 1ps
module isak_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [isak_pkg::DIV_DVD_W-1:0]  dividend,
  input  logic [isak_pkg::DIV_DVS_W-1:0]  divisor,
  output logic                            done,
  output logic [isak_pkg::DIV_DVD_W-1:0]  quotient
);
  import isak_pkg::*;

  localparam int STEP_W = $clog2(DIV_DVD_W);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIV_DVD_W-1:0]  quo;
  logic [DIV_DVS_W-1:0]  rem;
  logic [DIV_DVS_W-1:0]  dsr;
  logic [DIV_DVS_W:0]    trial;
  logic                  fits;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial    = {rem, quo[DIV_DVD_W-1]};
  assign fits     = trial >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        step <= STEP_W'(DIV_DVD_W - 1);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= DIV_DVS_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DIV_DVS_W-1:0];
        end
        quo <= {quo[DIV_DVD_W-2:0], fits};
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/imu_static_alignment_kalman_unit.sv =====
`timescale 1ns / 1ps
// Static alignment of a six-axis IMU. Each input beat is one sample (gyro x/y/z and
// accel x/y/z, signed Q16.16); each produces exactly one output beat holding the roll,
// pitch and yaw estimates, the running means of all six axes and two flags. A sample
// that departs from the mean by more than its threshold, or the MAX_SAMPLES-th
// sample, ends the alignment; from then on every output beat repeats the last one.
// The block takes one sample at a time. The time per still sample is set mostly by
// the shared divider, which yields one quotient bit per cycle and serves up to ten
// 64-bit divisions per still sample; a sample after the end goes straight to the
// output. Every sample is further held while the previous output beat still waits
// for m_tready.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata, by the user only
// while the block is idle; the block itself does not enforce this.
module imu_static_alignment_kalman_unit #(
  parameter int MAX_SAMPLES      = 65536,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (32 bits each)
  input  logic [191:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // roll_est, pitch_est, yaw_est, mean_gyro_x/y/z, mean_accel_x/y/z (32 bits each)
  output logic [287:0] m_tdata,
  // motion_seen, finished
  output logic [1:0]   m_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);
  import isak_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int ITER_N = (ANGLE_ITERATIONS < 32) ? ANGLE_ITERATIONS : 32;
  localparam int CW     = 36;
  localparam int MW     = 34;

  typedef enum logic [4:0] {
    S_IDLE, S_MEAN_GO, S_MEAN_WAIT, S_MOTION, S_SQ_Y, S_SQ_Z, S_SQ_SUM, S_ROOT,
    S_ATAN_INIT, S_ATAN_ITER, S_KAL_P, S_KAL_K, S_KAL_MUL, S_KAL_PN_GO, S_KAL_PN,
    S_KAL_UPD, S_KAL_APPLY, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [30:0] gyro_thr, accel_thr, proc_noise, meas_noise, init_cov;

  // Filter state.
  logic signed [SUM_W-1:0] sums [6];
  logic [CNT_W-1:0]        count;
  logic signed [31:0]      samp [6];
  logic signed [31:0]      mean [6];
  logic signed [31:0]      angle [2];
  logic signed [31:0]      meas [2];
  logic [30:0]             cov [2];
  logic                    done_flag;
  logic                    motion;

  // Sequencer working registers.
  logic [2:0]              mi;
  logic                    ax;
  logic [63:0]             sq_acc, sv, sr, sb;
  logic [4:0]              rc;
  logic [31:0]             horiz;
  logic signed [CW-1:0]    cx, cy;
  logic signed [31:0]      cz;
  logic [4:0]              it;
  logic [30:0]             kp;
  logic [31:0]             ks;
  logic [16:0]             kk;
  logic [30:0]             kpn;
  logic signed [2*MW-1:0]  prod;

  // Output registers.
  logic [287:0]            out_data;
  logic [1:0]              out_user;

  // Shared divider.
  logic                    div_start, div_done;
  logic [DIV_DVD_W-1:0]    div_dvd, div_quo;
  logic [DIV_DVS_W-1:0]    div_dvs;

  isak_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  logic signed [SUM_W-1:0] cur_sum;
  logic [SUM_W-1:0]        sum_mag;
  logic [31:0]             p_sum;
  logic [30:0]             p_cl;
  logic [31:0]             s_cl;

  assign cur_sum = sums[mi];
  assign sum_mag = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
  assign p_sum   = {1'b0, cov[ax]} + {1'b0, proc_noise};
  assign p_cl    = p_sum[31] ? MAX_P : p_sum[30:0];
  assign s_cl    = {1'b0, p_cl} + {1'b0, meas_noise};

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state)
      S_MEAN_GO: begin
        div_start = 1'b1;
        div_dvd   = DIV_DVD_W'(sum_mag);
        div_dvs   = DIV_DVS_W'(count);
      end
      S_KAL_P: begin
        div_start = (s_cl != '0);
        div_dvd   = DIV_DVD_W'({p_cl, 16'b0});
        div_dvs   = s_cl;
      end
      S_KAL_PN_GO: begin
        div_start = 1'b1;
        div_dvd   = DIV_DVD_W'(prod[61:0]);
        div_dvs   = ks;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Shared multiplier operand selection.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [32:0]   innov;

  assign innov = 33'(meas[ax]) - 33'(angle[ax]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ_Y: begin
        mul_a = MW'(mean[4]);
        mul_b = MW'(mean[4]);
      end
      S_SQ_Z: begin
        mul_a = MW'(mean[5]);
        mul_b = MW'(mean[5]);
      end
      S_KAL_MUL: begin
        mul_a = MW'({3'b0, kp});
        mul_b = MW'({3'b0, meas_noise});
      end
      S_KAL_UPD: begin
        mul_a = MW'({17'b0, kk});
        mul_b = MW'(innov);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Motion test over all six axes of the newest sample.
  logic moving;
  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        m;
    moving = 1'b0;
    for (int i = 0; i < 6; i++) begin
      d = 33'(samp[i]) - 33'(mean[i]);
      m = d[32] ? 33'(-d) : 33'(d);
      if (m > {2'b0, (i < 3) ? gyro_thr : accel_thr}) moving = 1'b1;
    end
  end

  // Square root step.
  logic [63:0] root_t;
  assign root_t = sr + sb;

  // CORDIC step.
  logic signed [CW-1:0] xs, ys;
  logic signed [31:0]   tab;
  assign xs  = cx >>> it;
  assign ys  = cy >>> it;
  assign tab = 32'(signed'({1'b0, atan_q16(it)}));

  // CORDIC start vector for the current angle.
  logic signed [CW-1:0] y0, x0;
  assign y0 = ax ? -CW'(mean[3]) : CW'(mean[4]);
  assign x0 = ax ? CW'({1'b0, horiz}) : CW'(mean[5]);

  // Angle update with saturation; the product is floored by the arithmetic shift.
  logic signed [52:0] upd;
  logic signed [31:0] upd_sat;
  assign upd = 53'(angle[ax]) + 53'($signed(prod[2*MW-1:16]));
  always_comb begin
    if (upd > 53'sd2147483647)       upd_sat = 32'sh7FFF_FFFF;
    else if (upd < -53'sd2147483648) upd_sat = 32'sh8000_0000;
    else                             upd_sat = upd[31:0];
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state      <= S_IDLE;
      gyro_thr   <= RST_GYRO_THR;
      accel_thr  <= RST_ACCEL_THR;
      proc_noise <= RST_PROC_NOISE;
      meas_noise <= RST_MEAS_NOISE;
      init_cov   <= RST_INIT_COV;
      for (int i = 0; i < 6; i++) sums[i] <= '0;
      angle[0]   <= '0;
      angle[1]   <= '0;
      count      <= '0;
      done_flag  <= 1'b0;
      motion     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_GYRO_THR:   gyro_thr   <= cfg_wdata;
          REG_ACCEL_THR:  accel_thr  <= cfg_wdata;
          REG_PROC_NOISE: proc_noise <= cfg_wdata;
          REG_MEAS_NOISE: meas_noise <= cfg_wdata;
          REG_INIT_COV:   init_cov   <= cfg_wdata;
          default: begin
          end
        endcase
      end
      // The output state sets its own valid, so it is only cleared elsewhere.
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (done_flag) begin
              state <= S_OUT;
            end else begin
              if (count == '0) begin
                cov[0] <= init_cov;
                cov[1] <= init_cov;
              end
              for (int i = 0; i < 6; i++) begin
                samp[i] <= s_tdata[32*i +: 32];
                sums[i] <= sums[i] + SUM_W'(signed'(s_tdata[32*i +: 32]));
              end
              count <= count + 1'b1;
              mi    <= '0;
              state <= S_MEAN_GO;
            end
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (div_done) begin
            mean[mi] <= cur_sum[SUM_W-1] ? -div_quo[31:0] : div_quo[31:0];
            if (mi == 3'd5) begin
              state <= S_MOTION;
            end else begin
              mi    <= mi + 1'b1;
              state <= S_MEAN_GO;
            end
          end
        end
        S_MOTION: begin
          motion <= moving;
          if (moving) begin
            done_flag <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_SQ_Y;
          end
        end
        S_SQ_Y: state <= S_SQ_Z;
        S_SQ_Z: begin
          sq_acc <= prod[63:0];
          state  <= S_SQ_SUM;
        end
        S_SQ_SUM: begin
          sv    <= sq_acc + prod[63:0];
          sr    <= '0;
          sb    <= 64'h4000_0000_0000_0000;
          rc    <= '0;
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (sv >= root_t) begin
            sv <= sv - root_t;
            sr <= (sr >> 1) + sb;
          end else begin
            sr <= sr >> 1;
          end
          sb <= sb >> 2;
          rc <= rc + 1'b1;
          if (rc == 5'd31) begin
            ax    <= 1'b0;
            state <= S_ATAN_INIT;
          end
        end
        S_ATAN_INIT: begin
          if (ax == 1'b0) horiz <= sr[31:0];
          it <= '0;
          if (x0 == '0 && y0 == '0) begin
            meas[ax] <= '0;
            if (ax) begin
              ax    <= 1'b0;
              state <= S_KAL_P;
            end else begin
              ax <= 1'b1;
            end
          end else begin
            if (x0 < 0) begin
              cz <= (y0 >= 0) ? PI_Q16 : -PI_Q16;
              cx <= -x0;
              cy <= -y0;
            end else begin
              cz <= '0;
              cx <= x0;
              cy <= y0;
            end
            state <= S_ATAN_ITER;
          end
        end
        S_ATAN_ITER: begin
          if (cy > 0) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + tab;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - tab;
          end
          it <= it + 1'b1;
          if (it == 5'(ITER_N - 1)) begin
            meas[ax] <= (cy > 0) ? cz + tab : cz - tab;
            if (ax) begin
              ax    <= 1'b0;
              state <= S_KAL_P;
            end else begin
              ax    <= 1'b1;
              state <= S_ATAN_INIT;
            end
          end
        end
        S_KAL_P: begin
          kp <= p_cl;
          ks <= s_cl;
          if (s_cl == '0) begin
            kk    <= '0;
            kpn   <= '0;
            state <= S_KAL_UPD;
          end else begin
            state <= S_KAL_K;
          end
        end
        S_KAL_K: begin
          if (div_done) begin
            kk    <= div_quo[16:0];
            state <= S_KAL_MUL;
          end
        end
        S_KAL_MUL:   state <= S_KAL_PN_GO;
        S_KAL_PN_GO: state <= S_KAL_PN;
        S_KAL_PN: begin
          if (div_done) begin
            kpn   <= div_quo[30:0];
            state <= S_KAL_UPD;
          end
        end
        S_KAL_UPD: state <= S_KAL_APPLY;
        S_KAL_APPLY: begin
          angle[ax] <= upd_sat;
          cov[ax]   <= kpn;
          if (ax) begin
            if (32'(count) >= 32'(MAX_SAMPLES)) done_flag <= 1'b1;
            state <= S_OUT;
          end else begin
            ax    <= 1'b1;
            state <= S_KAL_P;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_data <= {mean[5], mean[4], mean[3], mean[2], mean[1], mean[0],
                         32'd0, angle[1], angle[0]};
            out_user <= {done_flag, motion};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_imu_static_alignment_kalman_unit.sv =====
`timescale 1ns / 1ps
module tb_imu_static_alignment_kalman_unit;
  import isak_pkg::*;

  localparam int  SAMPLE_LIMIT = 65536;
  localparam int  CORDIC_STEPS = 16;
  localparam longint PI_VAL    = 205887;
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam int  HOLD_CYCLES  = 3000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [30:0]  cfg_wdata;

  imu_static_alignment_kalman_unit #(
    .MAX_SAMPLES(SAMPLE_LIMIT),
    .ANGLE_ITERATIONS(CORDIC_STEPS)
  ) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Expected output beat: nine Q16.16 words and the two flags.
  typedef struct {
    logic [287:0] words;
    logic [1:0]   flags;
  } alignment_beat_t;

  logic [191:0]    sample_queue[$];
  alignment_beat_t alignment_expected[$];

  // Shadow copy of the alignment state and the registers.
  longint      sum_acc[6];
  int unsigned n_samples;
  longint      angle_acc[3];
  longint      p_diag[3];
  bit          align_done;
  bit          motion_latch;
  longint      thr_gyro, thr_accel, q_noise, r_noise, p_start;

  int     mismatches;
  longint cycles;
  bit     calm;
  int     hold_req, hold_seen, hold_left;
  bit     sample_taken;

  // Clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint mean_of(int a);
    if (n_samples == 0) return 0;
    return sum_acc[a] / longint'(n_samples);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_VAL : -PI_VAL;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      t = x;
      if (y > 0) begin
        x = x + (y >>> i);
        y = y - (t >>> i);
        z = z + longint'(atan_q16(5'(i)));
      end else begin
        x = x - (y >>> i);
        y = y + (t >>> i);
        z = z - longint'(atan_q16(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One predict and update step per axis; the covariance stays diagonal.
  function automatic void filter_update();
    longint mx, my, mz, horiz, p, s, k, pn;
    longint meas[3];
    mx = mean_of(3);
    my = mean_of(4);
    mz = mean_of(5);
    horiz = root_floor(longint'(my < 0 ? -my : my) * longint'(my < 0 ? -my : my)
                       + longint'(mz < 0 ? -mz : mz) * longint'(mz < 0 ? -mz : mz));
    meas[0] = vector_angle(my, mz);
    meas[1] = vector_angle(-mx, horiz);
    meas[2] = angle_acc[2];
    for (int i = 0; i < 3; i++) begin
      p = p_diag[i] + q_noise;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < 0) p = 0;
      s = p + r_noise;
      k = 0;
      pn = 0;
      if (s != 0) begin
        k = (p * 65536) / s;
        pn = (p * r_noise) / s;
      end
      angle_acc[i] = clip32(angle_acc[i] + ((k * (meas[i] - angle_acc[i])) >>> 16));
      p_diag[i] = pn;
    end
  endfunction

  // Works out the output beat that one accepted sample causes.
  function automatic alignment_beat_t align_sample(logic [191:0] d);
    alignment_beat_t b;
    longint smp[6];
    longint dev, lim;
    bit moving;
    if (!align_done) begin
      moving = 1'b0;
      if (n_samples == 0) begin
        for (int i = 0; i < 3; i++) p_diag[i] = p_start;
      end
      for (int i = 0; i < 6; i++) begin
        smp[i] = longint'($signed(d[32*i +: 32]));
        sum_acc[i] = sum_acc[i] + smp[i];
      end
      n_samples++;
      for (int i = 0; i < 6; i++) begin
        dev = smp[i] - mean_of(i);
        lim = (i < 3) ? thr_gyro : thr_accel;
        if (dev < 0) dev = -dev;
        if (dev > lim) moving = 1'b1;
      end
      motion_latch = moving;
      if (!moving) filter_update();
      if (moving || n_samples >= SAMPLE_LIMIT) align_done = 1'b1;
    end
    for (int i = 0; i < 3; i++) b.words[32*i +: 32] = angle_acc[i][31:0];
    for (int i = 0; i < 6; i++) b.words[32*(3+i) +: 32] = mean_of(i) % 64'sh1_0000_0000;
    b.flags = {align_done, motion_latch};
    return b;
  endfunction

  // Prediction, checking and the cycle limit, all at the rising edge.
  always @(posedge clk) begin
    alignment_beat_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      if (!rst && s_tvalid && s_tready) begin
        alignment_expected = {alignment_expected, align_sample(s_tdata)};
        sample_taken = 1'b1;
      end
      if (!rst && m_tvalid && m_tready) begin
        if (alignment_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected output beat %h %b", m_tdata, m_tuser);
        end else begin
          want = alignment_expected.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (m_tdata[32*i +: 32] !== want.words[32*i +: 32]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("word %0d: expected %h, got %h", i, want.words[32*i +: 32],
                         m_tdata[32*i +: 32]);
            end
          end
          for (int i = 0; i < 2; i++) begin
            if (m_tuser[i] !== want.flags[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("flag %0d: expected %b, got %b", i, want.flags[i], m_tuser[i]);
            end
          end
        end
      end
    end
  end

  // Sample driver: offers the next queued sample once the previous beat has gone.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      sample_taken = 1'b0;
    end else if (!s_tvalid || sample_taken) begin
      sample_taken = 1'b0;
      if (sample_queue.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        s_tvalid <= 1'b1;
        s_tdata  <= sample_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side readiness, with a long hold-off on request.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 31);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    case (idx)
      REG_GYRO_THR:   thr_gyro  = longint'(val);
      REG_ACCEL_THR:  thr_accel = longint'(val);
      REG_PROC_NOISE: q_noise   = longint'(val);
      REG_MEAS_NOISE: r_noise   = longint'(val);
      REG_INIT_COV:   p_start   = longint'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every queued sample has gone and every result has come back.
  task automatic drain();
    do @(negedge clk);
    while (sample_queue.size() != 0 || s_tvalid || alignment_expected.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Appends one sample to the pending queue.
  task automatic queue_sample(logic [191:0] d);
    sample_queue = {sample_queue, d};
  endtask

  function automatic logic [191:0] pack6(int gx, int gy, int gz, int ax, int ay, int az);
    return {az, ay, ax, gz, gy, gx};
  endfunction

  function automatic int wide_word();
    return int'($urandom_range(32'h7FFF_FFFF)) - 32'sd1073741824;
  endfunction

  // Still sample: either wide values around zero or a gravity vector with noise.
  function automatic logic [191:0] still_sample();
    int v[6];
    int g;
    if ($urandom_range(2) == 0) begin
      for (int i = 0; i < 6; i++) v[i] = wide_word();
    end else begin
      g = 642252;
      for (int i = 0; i < 3; i++) v[i] = int'($urandom_range(4000)) - 2000;
      v[3] = int'($urandom_range(2 * g)) - g;
      v[4] = int'($urandom_range(2 * g)) - g;
      v[5] = ($urandom_range(1) != 0) ? -g + int'($urandom_range(9000)) :
                                         g - int'($urandom_range(9000));
    end
    return pack6(v[0], v[1], v[2], v[3], v[4], v[5]);
  endfunction

  task automatic queue_still(int n);
    repeat (n) queue_sample(still_sample());
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = REG_GYRO_THR;
    cfg_wdata = '0;
    m_tready = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    calm = 1'b0;
    mismatches = 0;
    cycles = 0;
    hold_req = 0;
    hold_seen = 0;
    hold_left = 0;
    sample_taken = 1'b0;
    for (int i = 0; i < 6; i++) sum_acc[i] = 0;
    for (int i = 0; i < 3; i++) angle_acc[i] = 0;
    n_samples = 0;
    align_done = 1'b0;
    motion_latch = 1'b0;
    thr_gyro = RST_GYRO_THR;
    thr_accel = RST_ACCEL_THR;
    q_noise = RST_PROC_NOISE;
    r_noise = RST_MEAS_NOISE;
    p_start = RST_INIT_COV;
    for (int i = 0; i < 3; i++) p_diag[i] = p_start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Wide thresholds keep the run going; the spare index must be ignored.
    write_reg(REG_INIT_COV, MAX_P);
    write_reg(REG_GYRO_THR, MAX_P);
    write_reg(REG_ACCEL_THR, MAX_P);
    write_reg(REG_SPARE, 31'h0000_0001);

    // Directed: zero vector first, then the field extremes, then assorted accel vectors.
    queue_sample(pack6(0, 0, 0, 0, 0, 0));
    queue_sample(pack6(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    queue_sample(pack6(0, 0, 0, 0, 0, 0));
    queue_sample(pack6(100, -100, 5, 3000, 200000, -642252));
    queue_sample(pack6(-7, 9, 1, -3000, -200000, -642252));
    queue_sample(pack6(0, 0, 0, 642252, 0, 0));
    queue_sample(pack6(0, 0, 0, -642252, -5, 642252));
    queue_sample(pack6(1, 1, 1, 0, 0, 1));
    drain();

    // Default noise; the result side holds off while samples wait in the queue.
    hold_req++;
    queue_still(500);
    drain();

    // Largest process noise, no measurement noise; no idling in this phase.
    write_reg(REG_PROC_NOISE, MAX_P);
    write_reg(REG_MEAS_NOISE, 31'd0);
    calm = 1'b1;
    queue_still(300);
    drain();
    calm = 1'b0;

    // Both noises zero: innovation variance of zero.
    write_reg(REG_PROC_NOISE, 31'd0);
    queue_still(200);
    drain();

    // Largest measurement noise.
    write_reg(REG_MEAS_NOISE, MAX_P);
    queue_still(300);
    drain();

    // Random noise settings.
    write_reg(REG_PROC_NOISE, 31'($urandom));
    write_reg(REG_MEAS_NOISE, 31'($urandom_range(200000)));
    queue_still(200);
    drain();

    // Zero thresholds: the first deviation stops alignment, later samples are ignored.
    write_reg(REG_GYRO_THR, 31'd0);
    write_reg(REG_ACCEL_THR, 31'd0);
    queue_sample(pack6(3, 0, 0, 0, 0, 0));
    repeat (100) queue_sample({$urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom});
    drain();

    repeat (50) @(negedge clk);
    if (mismatches == 0 && alignment_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
